// ===== rtl/byte_frame_deframer_assert.svh =====
// Assertion macros for the byte frame deframer.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef BYTE_FRAME_DEFRAMER_ASSERT_SVH
`define BYTE_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define BFD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bfd assertion failed");
`define BFD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bfd assertion failed");
`else
`define BFD_ASSERT(lbl, clk, rstn, prop)
`define BFD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/bfd_pkg.sv =====
// Types and codes for the byte frame deframer.
// No dependencies; used by byte_frame_deframer.
package bfd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CTRL = 3'd1,
        PH_SEQ  = 3'd2,
        PH_LEN  = 3'd3,
        PH_CMD  = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6,
        PH_END  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_BUSY    = 3'd0,
        EV_PAYLOAD = 3'd1,
        EV_OK      = 3'd2,
        EV_LEN_ERR = 3'd3,
        EV_SUM_ERR = 3'd4,
        EV_END_ERR = 3'd5
    } event_t;

    localparam logic [1:0] CFG_START_MARK = 2'd0;
    localparam logic [1:0] CFG_END_MARK   = 2'd1;
    localparam logic [1:0] CFG_MAX_LENGTH = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [2:0] channel;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [2:0]  source_channel;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_control;
        logic [7:0]  frame_sequence;
        logic [15:0] frame_length;
        logic [15:0] frame_command;
    } out_beat_t;

    typedef struct packed {
        phase_t      parse_phase;
        logic        upper_half_next;
        logic [7:0]  held_control;
        logic [7:0]  held_sequence;
        logic [15:0] held_length;
        logic [15:0] held_command;
        logic [15:0] payload_count;
        logic [7:0]  running_sum;
    } chan_state_t;

endpackage

// ===== rtl/byte_frame_deframer.sv =====
// Byte frame deframer: per-channel frame parser with an additive checksum.
// Depends on bfd_pkg and byte_frame_deframer_assert.svh.
// Path: input register, then result register; back-pressure on m_ready holds both.
// Throughput: one beat per cycle unless m_ready stalls; state read and written same cycle.
// Reset (aresetn low, synchronous): all parsers hunt, held fields zero, config to defaults.
`include "byte_frame_deframer_assert.svh"

module byte_frame_deframer #(
    parameter int CHANNELS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bfd_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bfd_pkg::out_beat_t   m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [7:0]           start_mark_reg;
    logic [7:0]           end_mark_reg;
    logic [15:0]          max_length_reg;

    logic                 in_valid_reg;
    bfd_pkg::in_beat_t    in_beat_reg;
    logic                 m_valid_reg;
    bfd_pkg::out_beat_t   m_beat_reg;
    bfd_pkg::out_beat_t   m_beat_next;

    bfd_pkg::chan_state_t state_reg [CHANNELS];
    bfd_pkg::chan_state_t cur;
    bfd_pkg::chan_state_t state_next;

    logic                 out_take;
    logic                 advance;
    logic                 in_range;
    logic [3:0]           ch_ext;
    logic [IDX_W-1:0]     idx;
    logic [7:0]           b;
    logic [7:0]           sum_add;
    logic [15:0]          len_full;
    logic [15:0]          cnt_inc;
    bfd_pkg::event_t      kind;
    logic [7:0]           pbyte;
    logic [15:0]          pidx;

    assign cfg_ready = 1'b1;
    assign out_take  = !m_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_take;
    assign advance   = in_valid_reg && out_take;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_mark_reg <= 8'd165;
            end_mark_reg   <= 8'd90;
            max_length_reg <= 16'd1024;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bfd_pkg::CFG_START_MARK: start_mark_reg <= cfg_data[7:0];
                bfd_pkg::CFG_END_MARK:   end_mark_reg   <= cfg_data[7:0];
                bfd_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_take) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_data;
        end
        if (advance) begin
            m_beat_reg <= m_beat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                state_reg[i] <= '0;
            end
        end else if (advance && in_range) begin
            state_reg[idx] <= state_next;
        end
    end

    assign b        = in_beat_reg.rx_byte;
    assign ch_ext   = {1'b0, in_beat_reg.channel};
    assign idx      = ch_ext[IDX_W-1:0];
    assign in_range = {2'b00, in_beat_reg.channel} < 5'(CHANNELS);
    assign cur      = in_range ? state_reg[idx] : '0;
    assign sum_add  = cur.running_sum + b;
    assign len_full = {b, cur.held_length[7:0]};
    assign cnt_inc  = cur.payload_count + 16'd1;

    always_comb begin
        state_next = cur;
        kind       = bfd_pkg::EV_BUSY;
        pbyte      = 8'd0;
        pidx       = 16'd0;
        unique case (cur.parse_phase)
            bfd_pkg::PH_HUNT: begin
                if (b == start_mark_reg) begin
                    state_next.parse_phase     = bfd_pkg::PH_CTRL;
                    state_next.running_sum     = b;
                    state_next.upper_half_next = 1'b0;
                end
            end
            bfd_pkg::PH_CTRL: begin
                state_next.held_control = b;
                state_next.running_sum  = sum_add;
                state_next.parse_phase  = bfd_pkg::PH_SEQ;
            end
            bfd_pkg::PH_SEQ: begin
                state_next.held_sequence   = b;
                state_next.running_sum     = sum_add;
                state_next.parse_phase     = bfd_pkg::PH_LEN;
                state_next.upper_half_next = 1'b0;
            end
            bfd_pkg::PH_LEN: begin
                state_next.running_sum = sum_add;
                if (!cur.upper_half_next) begin
                    state_next.held_length     = {8'd0, b};
                    state_next.upper_half_next = 1'b1;
                end else begin
                    state_next.held_length     = len_full;
                    state_next.upper_half_next = 1'b0;
                    if (len_full < 16'd2 || len_full > max_length_reg) begin
                        state_next.parse_phase = bfd_pkg::PH_HUNT;
                        kind                   = bfd_pkg::EV_LEN_ERR;
                    end else begin
                        state_next.parse_phase = bfd_pkg::PH_CMD;
                    end
                end
            end
            bfd_pkg::PH_CMD: begin
                state_next.running_sum = sum_add;
                if (!cur.upper_half_next) begin
                    state_next.held_command    = {8'd0, b};
                    state_next.upper_half_next = 1'b1;
                end else begin
                    state_next.held_command    = {b, cur.held_command[7:0]};
                    state_next.upper_half_next = 1'b0;
                    state_next.payload_count   = 16'd0;
                    state_next.parse_phase     = (cur.held_length == 16'd2) ?
                                                 bfd_pkg::PH_SUM : bfd_pkg::PH_DATA;
                end
            end
            bfd_pkg::PH_DATA: begin
                state_next.running_sum   = sum_add;
                state_next.payload_count = cnt_inc;
                kind                     = bfd_pkg::EV_PAYLOAD;
                pbyte                    = b;
                pidx                     = cur.payload_count;
                if (({1'b0, cnt_inc} + 17'd2) >= {1'b0, cur.held_length}) begin
                    state_next.parse_phase = bfd_pkg::PH_SUM;
                end
            end
            bfd_pkg::PH_SUM: begin
                if (b != cur.running_sum) begin
                    state_next.parse_phase = bfd_pkg::PH_HUNT;
                    kind                   = bfd_pkg::EV_SUM_ERR;
                end else begin
                    state_next.parse_phase = bfd_pkg::PH_END;
                end
            end
            bfd_pkg::PH_END: begin
                state_next.parse_phase = bfd_pkg::PH_HUNT;
                kind = (b == end_mark_reg) ? bfd_pkg::EV_OK : bfd_pkg::EV_END_ERR;
            end
        endcase
    end

    always_comb begin
        m_beat_next                = '0;
        m_beat_next.source_channel = in_beat_reg.channel;
        if (in_range) begin
            m_beat_next.event_kind     = kind;
            m_beat_next.payload_byte   = pbyte;
            m_beat_next.payload_index  = pidx;
            m_beat_next.frame_control  = state_next.held_control;
            m_beat_next.frame_sequence = state_next.held_sequence;
            m_beat_next.frame_length   = state_next.held_length;
            m_beat_next.frame_command  = state_next.held_command;
        end
    end

    `BFD_ASSERT_ALWAYS(a_no_beat_after_reset, aclk, !aresetn |=> !m_valid_reg)
    `BFD_ASSERT(a_in_hold_on_stall, aclk, aresetn, (in_valid_reg && !out_take) |=> (in_valid_reg && $stable(in_beat_reg)))
    `BFD_ASSERT(a_index_in_frame, aclk, aresetn, (m_valid_reg && m_beat_reg.event_kind == bfd_pkg::EV_PAYLOAD) |-> (({1'b0, m_beat_reg.payload_index} + 17'd2) < {1'b0, m_beat_reg.frame_length}))
    `BFD_ASSERT(a_idle_channel_busy, aclk, aresetn, (m_valid_reg && ({2'b00, m_beat_reg.source_channel} >= 5'(CHANNELS))) |-> (m_beat_reg.event_kind == bfd_pkg::EV_BUSY))

endmodule
